// ===== design/clamped_edge_2d_convolution_assert.svh =====
// Assertion macros for the convolution block
`ifndef CLAMPED_EDGE_2D_CONVOLUTION_ASSERT_SVH
`define CLAMPED_EDGE_2D_CONVOLUTION_ASSERT_SVH

// same-cycle implication
`define CEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cec_pkg.sv =====
`timescale 1ns / 1ps
package cec_pkg;

    localparam int PIX_BITS      = 16;
    localparam int COEF_BITS     = 16;
    localparam int IDX_BITS      = 8;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int IN_BITS       = IDX_BITS + COEF_BITS + 4 * PIX_BITS;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT = 2'd2;

    // word kinds on tuser
    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TAP   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ALPHA = 4'b1000
    } state_t;

endpackage

// ===== design/clamped_edge_2d_convolution.sv =====
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                 | Contents
// s_axis    | in  | s_tvalid / s_tready       | tuser kind, tdata coefficient or pixel
// m_axis    | out | m_tvalid / m_tready       | tdata filtered pixel, tlast run_last
// cfg       | in  | cfg_we (no wait)          | cfg_addr, cfg_data
// A coefficient word or a pixel word is taken only while the sequencer is idle.
// For each filtered pixel, one window tap per cycle is read from
// the line memory, which has a single read port, then the alpha read and the output load.
// A pixel word causes up to (R+1)^2 filtered pixels; no word is taken until all are loaded.
// Reset clears counters and control; line and kernel memories are not cleared.
// A stalled output holds the sequencer in the alpha step until the output register frees.
`include "clamped_edge_2d_convolution_assert.svh"
module clamped_edge_2d_convolution
    import cec_pkg::*;
#(
    parameter int MAX_RADIUS   = 7,
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 4096,
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // coef_index, coef_value, red_in, green_in, blue_in, alpha_in
    input  logic [IN_BITS-1:0]           s_tdata,
    // kind
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_row, out_col, red_out, green_out, blue_out, alpha_out, zero pad
    output logic [((($clog2(MAX_HEIGHT) + $clog2(MAX_WIDTH) + 4 * PIX_BITS) + 7) / 8) * 8 - 1:0]
                                         m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int CB       = $clog2(MAX_WIDTH);
    localparam int RB       = $clog2(MAX_HEIGHT);
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int SB       = $clog2(SIDE_MAX);
    localparam int TB       = $clog2(SIDE_MAX);
    localparam int KSIZE    = SIDE_MAX * SIDE_MAX;
    localparam int KB       = $clog2(KSIZE);
    localparam int AB       = SB + CB;
    localparam int LDEPTH   = (1 << SB) * MAX_WIDTH;
    localparam int RS       = RB + 2;
    localparam int CS       = CB + 2;
    localparam int PROD_W   = PIX_BITS + COEF_BITS;
    localparam int ACC_W    = PROD_W + KB;
    localparam int OUT_BITS = RB + CB + 4 * PIX_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [PIX_BITS-1:0] CH_MASK =
        (CHANNEL_BITS >= PIX_BITS) ? {PIX_BITS{1'b1}} : PIX_BITS'((1 << CHANNEL_BITS) - 1);
    localparam logic [ACC_W-1:0] CH_MAX = ACC_W'((64'd1 << CHANNEL_BITS) - 64'd1);
    localparam logic [CB:0] RST_W = (MAX_WIDTH < 1024) ? (CB+1)'(MAX_WIDTH) : (CB+1)'(1024);
    localparam logic [RB:0] RST_H = (MAX_HEIGHT < 1024) ? (RB+1)'(MAX_HEIGHT) : (RB+1)'(1024);

    // memories
    logic [4*PIX_BITS-1:0] line_mem [0:LDEPTH-1];
    logic [COEF_BITS-1:0]  kern_mem [0:KSIZE-1];

    // control and counters
    state_t        state_reg, state_next;
    logic [2:0]    eff_r_reg;
    logic [CB:0]   eff_w_reg;
    logic [RB:0]   eff_h_reg;
    logic [RB-1:0] y_reg;
    logic [CB-1:0] x_reg;
    logic [RB-1:0] r_reg, r1_reg;
    logic [CB-1:0] c_reg, c0_reg, c1_reg;
    logic [TB-1:0] li_reg, mi_reg;
    logic [KB-1:0] ki_reg;
    logic          v1_reg, v2_reg;
    logic          m_tvalid_reg;

    // datapath
    logic [4*PIX_BITS-1:0] ld_reg;
    logic [COEF_BITS-1:0]  kd_reg;
    logic [PROD_W-1:0]     prod_reg [0:2];
    logic [ACC_W-1:0]      acc_reg  [0:2];
    logic [OUT_W-1:0]      m_tdata_reg;
    logic                  m_tlast_reg;

    logic accept, coef_wr, pix_acc, rd_en, tap_issue, tap_end, out_load, out_last;
    logic [AB-1:0] rd_addr;
    logic [AB-1:0] wr_addr;
    logic [RB-1:0] y_eff;
    logic [CB-1:0] x_eff;
    logic          y_wrap;
    logic signed [RS-1:0] hm1, ys, r0s, r1s, rs, rr;
    logic signed [CS-1:0] wm1, xs, c0s, c1s, cs, cc;
    logic [TB-1:0] side_m1;
    logic [PIX_BITS-1:0] sat_val [0:2];
    logic [ACC_W-1:0]    rnd [0:2];
    logic [IDX_BITS-1:0] cidx;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign coef_wr = accept && (s_tuser == KIND_COEF);
    assign pix_acc = accept && (s_tuser == KIND_PIXEL);
    assign cidx    = s_tdata[IDX_BITS-1:0];
    assign side_m1 = TB'({eff_r_reg, 1'b0});

    // position of the incoming pixel, wrapped if beyond the frame
    always_comb
    begin
        y_wrap = ({1'b0, y_reg} >= eff_h_reg) || ({1'b0, x_reg} >= eff_w_reg);
        y_eff  = y_wrap ? '0 : y_reg;
        x_eff  = y_wrap ? '0 : x_reg;
        wr_addr = {y_eff[SB-1:0], x_eff};
    end

    // range of outputs completed by this pixel
    always_comb
    begin
        hm1 = $signed({1'b0, eff_h_reg}) - RS'(1);
        wm1 = $signed({1'b0, eff_w_reg}) - CS'(1);
        ys  = $signed({2'b00, y_eff});
        xs  = $signed({2'b00, x_eff});
        if (ys == hm1)
        begin
            r0s = hm1 - $signed(RS'(eff_r_reg));
            if (r0s < 0)
                r0s = '0;
            r1s = hm1;
        end
        else
        begin
            r0s = ys - $signed(RS'(eff_r_reg));
            r1s = r0s;
        end
        if (xs == wm1)
        begin
            c0s = wm1 - $signed(CS'(eff_r_reg));
            if (c0s < 0)
                c0s = '0;
            c1s = wm1;
        end
        else
        begin
            c0s = xs - $signed(CS'(eff_r_reg));
            c1s = c0s;
        end
    end

    // clamped window tap coordinates
    always_comb
    begin
        rs = $signed({2'b00, r_reg}) - $signed(RS'(eff_r_reg)) + $signed(RS'(li_reg));
        cs = $signed({2'b00, c_reg}) - $signed(CS'(eff_r_reg)) + $signed(CS'(mi_reg));
        if (rs < 0)
            rr = '0;
        else if (rs > hm1)
            rr = hm1;
        else
            rr = rs;
        if (cs < 0)
            cc = '0;
        else if (cs > wm1)
            cc = wm1;
        else
            cc = cs;
    end

    assign tap_issue = (state_reg == S_TAP);
    assign tap_end   = (li_reg == side_m1) && (mi_reg == side_m1);
    assign out_load  = (state_reg == S_ALPHA) && (!m_tvalid_reg || m_tready);
    assign out_last  = (r_reg == r1_reg) && (c_reg == c1_reg);
    assign rd_en     = tap_issue || ((state_reg == S_DRAIN) && !v1_reg && !v2_reg);
    assign rd_addr   = tap_issue ? {rr[SB-1:0], cc[CB-1:0]} : {r_reg[SB-1:0], c_reg};

    // line memory
    always_ff @(posedge clk)
    begin
        if (pix_acc)
            line_mem[wr_addr] <= {s_tdata[IDX_BITS+COEF_BITS+3*PIX_BITS +: PIX_BITS] & CH_MASK,
                                  s_tdata[IDX_BITS+COEF_BITS+2*PIX_BITS +: PIX_BITS] & CH_MASK,
                                  s_tdata[IDX_BITS+COEF_BITS+PIX_BITS +: PIX_BITS] & CH_MASK,
                                  s_tdata[IDX_BITS+COEF_BITS +: PIX_BITS] & CH_MASK};
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            ld_reg <= line_mem[rd_addr];
    end

    // kernel memory
    always_ff @(posedge clk)
    begin
        if (coef_wr && ({{(32-IDX_BITS){1'b0}}, cidx} < 32'(KSIZE)))
            kern_mem[cidx[KB-1:0]] <= s_tdata[IDX_BITS +: COEF_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (tap_issue)
            kd_reg <= kern_mem[ki_reg];
    end

    // multiply and accumulate
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (v1_reg)
                prod_reg[i] <= ld_reg[i*PIX_BITS +: PIX_BITS] * kd_reg;
            if (state_reg == S_IDLE || out_load)
                acc_reg[i] <= '0;
            else if (v2_reg)
                acc_reg[i] <= acc_reg[i] + ACC_W'(prod_reg[i]);
        end
    end

    // round half up and saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (acc_reg[i] + ACC_W'(32768)) >> 16;
            sat_val[i] = (rnd[i] > CH_MAX) ? CH_MAX[PIX_BITS-1:0] : rnd[i][PIX_BITS-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= OUT_W'({ld_reg[3*PIX_BITS +: PIX_BITS], sat_val[2], sat_val[1],
                                   sat_val[0], c_reg, r_reg});
            m_tlast_reg <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_acc && (r0s >= 0) && (c0s >= 0))
                    state_next = S_TAP;
            end
            S_TAP:
            begin
                if (tap_end)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_ALPHA;
            end
            S_ALPHA:
            begin
                if (out_load)
                    state_next = out_last ? S_IDLE : S_TAP;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eff_r_reg <= 3'd2;
            eff_w_reg <= RST_W;
            eff_h_reg <= RST_H;
            y_reg     <= '0;
            x_reg     <= '0;
            r_reg     <= '0;
            r1_reg    <= '0;
            c_reg     <= '0;
            c0_reg    <= '0;
            c1_reg    <= '0;
            li_reg    <= '0;
            mi_reg    <= '0;
            ki_reg    <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= tap_issue;
            v2_reg    <= v1_reg;

            // radius, width and height writes restart the frame
            if (cfg_we)
            begin
                priority case (cfg_addr)
                    REG_RADIUS:
                    begin
                        if (cfg_data[2:0] < 3'd2)
                            eff_r_reg <= 3'd2;
                        else if (32'(cfg_data[2:0]) > 32'(MAX_RADIUS))
                            eff_r_reg <= 3'(MAX_RADIUS);
                        else
                            eff_r_reg <= cfg_data[2:0];
                        y_reg <= '0;
                        x_reg <= '0;
                    end
                    REG_WIDTH:
                    begin
                        if (cfg_data[10:0] == '0)
                            eff_w_reg <= (CB+1)'(1);
                        else if (32'(cfg_data[10:0]) > 32'(MAX_WIDTH))
                            eff_w_reg <= (CB+1)'(MAX_WIDTH);
                        else
                            eff_w_reg <= (CB+1)'(cfg_data[10:0]);
                        y_reg <= '0;
                        x_reg <= '0;
                    end
                    REG_HEIGHT:
                    begin
                        if (cfg_data == '0)
                            eff_h_reg <= (RB+1)'(1);
                        else if (32'(cfg_data) > 32'(MAX_HEIGHT))
                            eff_h_reg <= (RB+1)'(MAX_HEIGHT);
                        else
                            eff_h_reg <= (RB+1)'(cfg_data);
                        y_reg <= '0;
                        x_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (pix_acc)
            begin
                // raster position advance
                if ({1'b0, x_eff} + (CB+1)'(1) >= eff_w_reg)
                begin
                    x_reg <= '0;
                    if ({1'b0, y_eff} + (RB+1)'(1) >= eff_h_reg)
                        y_reg <= '0;
                    else
                        y_reg <= y_eff + RB'(1);
                end
                else
                begin
                    x_reg <= x_eff + CB'(1);
                    y_reg <= y_eff;
                end
            end

            // output range captured at pixel accept
            if (pix_acc)
            begin
                r_reg  <= r0s[RB-1:0];
                r1_reg <= r1s[RB-1:0];
                c_reg  <= c0s[CB-1:0];
                c0_reg <= c0s[CB-1:0];
                c1_reg <= c1s[CB-1:0];
                li_reg <= '0;
                mi_reg <= '0;
                ki_reg <= '0;
            end

            // tap walk
            if (tap_issue)
            begin
                ki_reg <= ki_reg + KB'(1);
                if (mi_reg == side_m1)
                begin
                    mi_reg <= '0;
                    li_reg <= li_reg + TB'(1);
                end
                else
                    mi_reg <= mi_reg + TB'(1);
            end

            // next output of the run
            if (out_load)
            begin
                li_reg <= '0;
                mi_reg <= '0;
                ki_reg <= '0;
                if (c_reg == c1_reg)
                begin
                    c_reg <= c0_reg;
                    r_reg <= r_reg + RB'(1);
                end
                else
                    c_reg <= c_reg + CB'(1);
            end
        end
    end

    `CEC_ASSERT_NOW(a_pipe_in_tap, v2_reg, (state_reg == S_TAP) || (state_reg == S_DRAIN), "tap pipeline busy outside tap walk")
    `CEC_ASSERT_NOW(a_load_drained, out_load, !v1_reg && !v2_reg, "output loaded before accumulation drained")
    `CEC_ASSERT_NEXT(a_last_idle, out_load && out_last, state_reg == S_IDLE, "run end did not return to idle")

endmodule

// ===== dv/tb_clamped_edge_2d_convolution.sv =====
`timescale 1ns / 1ps
module tb_clamped_edge_2d_convolution;
    import cec_pkg::*;

    localparam int LINES    = 15;
    localparam int MAXW     = 1024;
    localparam int MAXH     = 4096;
    localparam int KSIZE    = 225;
    localparam int DOG_LIMIT = 40000;

    typedef struct {
        logic       kind;
        logic [87:0] data;
    } word_t;

    typedef struct {
        logic [11:0] row;
        logic [9:0]  col;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic        last;
    } pixel_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // coef_index, coef_value, red_in, green_in, blue_in, alpha_in
    logic [87:0] s_tdata = '0;
    // kind
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // out_row, out_col, red_out, green_out, blue_out, alpha_out, zero pad
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    clamped_edge_2d_convolution uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    // shadow state of the filter
    logic [15:0] line_mem [0:LINES*MAXW-1][0:3];
    logic [15:0] taps [0:KSIZE-1];
    int unsigned radius_reg = 2, width_reg = 1024, height_reg = 1024;
    int          row_pos = 0, col_pos = 0;

    word_t      pending_words [$];
    pixel_res_t filtered_q [$];
    bit         calm = 1'b0;
    bit         in_taken = 1'b0;
    int         fail_cnt = 0;
    int         result_cnt = 0;
    int         pixel_cnt = 0;
    int         phase_cnt = 0;
    int         item_cnt = 0;
    int         dog = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int eff_radius();
        return radius_reg < 2 ? 2 : (radius_reg > 7 ? 7 : radius_reg);
    endfunction

    function automatic int eff_dim(int unsigned v, int unsigned lim);
        return v == 0 ? 1 : (v > lim ? lim : v);
    endfunction

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // one filtered pixel at (r, c) from the shadow line memory
    function automatic pixel_res_t filter_at(int r, int c, int rad, int w, int h);
        pixel_res_t       e;
        longint unsigned  acc [3];
        longint unsigned  v;
        int               rr, cc, ki, base;
        acc = '{0, 0, 0};
        for (int l = -rad; l <= rad; l++)
        begin
            rr = clampi(r + l, 0, h - 1);
            base = (rr % LINES) * MAXW;
            for (int m = -rad; m <= rad; m++)
            begin
                cc = clampi(c + m, 0, w - 1);
                ki = (l + rad) * (2 * rad + 1) + (m + rad);
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += longint'(taps[ki]) * longint'(line_mem[base + cc][ch]);
            end
        end
        e.row = r[11:0];
        e.col = c[9:0];
        v = (acc[0] + 32768) >> 16; e.red   = v > 65535 ? 16'hFFFF : v[15:0];
        v = (acc[1] + 32768) >> 16; e.green = v > 65535 ? 16'hFFFF : v[15:0];
        v = (acc[2] + 32768) >> 16; e.blue  = v > 65535 ? 16'hFFFF : v[15:0];
        e.alpha = line_mem[(r % LINES) * MAXW + c][3];
        e.last = 1'b0;
        return e;
    endfunction

    // store a pixel and queue every filtered pixel it completes
    task automatic convolve_pixel(input logic [87:0] d);
        int rad, w, h, y, x, r0, r1, c0, c1;
        pixel_res_t e;
        rad = eff_radius();
        w = eff_dim(width_reg, MAXW);
        h = eff_dim(height_reg, MAXH);
        y = row_pos;
        x = col_pos;
        if (y >= h || x >= w)
        begin
            y = 0;
            x = 0;
        end
        for (int ch = 0; ch < 4; ch++)
            line_mem[(y % LINES) * MAXW + x][ch] = d[24 + 16 * ch +: 16];
        if (y == h - 1)
        begin
            r0 = h - 1 - rad; if (r0 < 0) r0 = 0; r1 = h - 1;
        end
        else
        begin
            r0 = y - rad; r1 = r0;
        end
        if (x == w - 1)
        begin
            c0 = w - 1 - rad; if (c0 < 0) c0 = 0; c1 = w - 1;
        end
        else
        begin
            c0 = x - rad; c1 = c0;
        end
        if (r0 >= 0 && c0 >= 0)
        begin
            for (int r = r0; r <= r1; r++)
                for (int c = c0; c <= c1; c++)
                begin
                    e = filter_at(r, c, rad, w, h);
                    e.last = (r == r1 && c == c1);
                    filtered_q.push_back(e);
                end
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        row_pos = y;
        col_pos = x;
    endtask

    // input acceptance, result check and watchdog
    always @(posedge clk)
    begin
        pixel_res_t e;
        logic [11:0] a_row;
        logic [9:0]  a_col;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
        begin
            if (s_tuser == KIND_COEF)
            begin
                if (s_tdata[7:0] < KSIZE) taps[s_tdata[7:0]] = s_tdata[23:8];
            end
            else
            begin
                convolve_pixel(s_tdata);
                pixel_cnt++;
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            result_cnt++;
            a_row = m_tdata[11:0];
            a_col = m_tdata[21:12];
            if (filtered_q.size() == 0)
            begin
                $error("unexpected result word row %0d col %0d", a_row, a_col);
                fail_cnt++;
            end
            else
            begin
                e = filtered_q.pop_front();
                if (a_row !== e.row)
                begin
                    $error("out_row: expected %0d got %0d", e.row, a_row); fail_cnt++;
                end
                if (a_col !== e.col)
                begin
                    $error("out_col: expected %0d got %0d", e.col, a_col); fail_cnt++;
                end
                if (m_tdata[37:22] !== e.red)
                begin
                    $error("red_out: expected %h got %h", e.red, m_tdata[37:22]); fail_cnt++;
                end
                if (m_tdata[53:38] !== e.green)
                begin
                    $error("green_out: expected %h got %h", e.green, m_tdata[53:38]);
                    fail_cnt++;
                end
                if (m_tdata[69:54] !== e.blue)
                begin
                    $error("blue_out: expected %h got %h", e.blue, m_tdata[69:54]); fail_cnt++;
                end
                if (m_tdata[85:70] !== e.alpha)
                begin
                    $error("alpha_out: expected %h got %h", e.alpha, m_tdata[85:70]);
                    fail_cnt++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("run_last: expected %b got %b", e.last, m_tlast); fail_cnt++;
                end
            end
        end
        // stall watchdog, only while work is outstanding
        if (in_taken || (m_tvalid && m_tready) ||
            (pending_words.size() == 0 && !s_tvalid && filtered_q.size() == 0))
            dog = 0;
        else
            dog++;
        if (dog >= DOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", dog);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender and receiver, both with random idle cycles outside the calm phase
    always @(negedge clk)
    begin
        word_t wd;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 31))
                begin
                    wd = pending_words.pop_front();
                    s_tuser  <= wd.kind;
                    s_tdata  <= wd.data;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= calm || $urandom_range(99) >= 31;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[CFG_DATA_BITS-1:0];
        if (idx == REG_RADIUS)      radius_reg = val & 7;
        else if (idx == REG_WIDTH)  width_reg  = val & 16'h7FF;
        else                        height_reg = val & 16'h1FFF;
        row_pos = 0;
        col_pos = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_coef(input int idx, input int unsigned val);
        word_t wd;
        wd.kind = KIND_COEF;
        wd.data = {$urandom(), $urandom(), val[15:0], idx[7:0]};
        pending_words.push_back(wd);
        item_cnt++;
    endtask

    // pixel with random channels; sel picks all zero, all ones or random
    task automatic push_pixel(input int sel);
        word_t wd;
        wd.kind = KIND_PIXEL;
        wd.data = 88'({$urandom(), $urandom(), $urandom()});
        if (sel == 1) wd.data[87:24] = '0;
        if (sel == 2) wd.data[87:24] = '1;
        pending_words.push_back(wd);
        item_cnt++;
    endtask

    // full kernel for the current radius; wmax bounds the weights
    task automatic load_kernel(input int unsigned wmax);
        int side;
        side = 2 * eff_radius() + 1;
        for (int i = 0; i < side * side; i++)
            push_coef(i, $urandom_range(wmax));
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || filtered_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        phase_cnt++;
    endtask

    initial
    begin
        int n, side;
        for (int i = 0; i < KSIZE; i++) taps[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small frame, extremes of weights and pixels, ignored indexes past the store
        write_reg(REG_RADIUS, 2);
        write_reg(REG_WIDTH, 5);
        write_reg(REG_HEIGHT, 4);
        push_coef(0, 16'hFFFF);
        push_coef(1, 0);
        for (int i = 2; i < 25; i++) push_coef(i, $urandom_range(4000));
        push_coef(225, 16'hFFFF);
        push_coef(255, 16'h1234);
        for (int i = 0; i < 23; i++) push_pixel(i % 3);
        drain();

        // radius below two, single-pixel frames, saturating weights
        write_reg(REG_RADIUS, 0);
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        for (int i = 0; i < 25; i++) push_coef(i, 16'hFFFF);
        for (int i = 0; i < 4; i++) push_pixel(i % 3);
        drain();

        // largest radius on a tiny frame
        write_reg(REG_RADIUS, 7);
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 2);
        load_kernel(700);
        for (int i = 0; i < 6; i++) push_pixel(i % 3);
        drain();

        // width past the maximum, one line; height past the maximum; then zero height and width
        write_reg(REG_RADIUS, 1);
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 1);
        load_kernel(5000);
        for (int i = 0; i < 10; i++) push_pixel(0);
        drain();
        write_reg(REG_RADIUS, 3);
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 8191);
        load_kernel(2000);
        for (int i = 0; i < 20; i++) push_pixel(0);
        drain();
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_WIDTH, 0);
        for (int i = 0; i < 3; i++) push_pixel(0);
        drain();

        // random settings and frames
        while (item_cnt < 420)
        begin
            calm = (phase_cnt == 6);
            if ($urandom_range(3) == 0)
                write_reg(REG_RADIUS, $urandom_range(7));
            else
                write_reg(REG_RADIUS, $urandom_range(3, 2));
            write_reg(REG_WIDTH, $urandom_range(12, 1));
            write_reg(REG_HEIGHT, $urandom_range(9, 1));
            side = 2 * eff_radius() + 1;
            if ($urandom_range(4) == 0)
                load_kernel(16'hFFFF);
            else
                load_kernel(131072 / (side * side));
            n = (eff_radius() > 4) ? $urandom_range(12, 3) : $urandom_range(60, 10);
            for (int i = 0; i < n; i++)
            begin
                push_pixel($urandom_range(9) == 0 ? $urandom_range(2, 1) : 0);
                if ($urandom_range(29) == 0) push_coef($urandom_range(255, 225), $urandom());
            end
            // the sender holds off until every result of this phase is in
            drain();
        end
        calm = 1'b0;

        repeat (300) @(posedge clk);
        $display("%0d pixel words in %0d phases, %0d filtered pixels checked",
                 pixel_cnt, phase_cnt, result_cnt);
        $display("radius 2 to 7, widths and heights from one to past the maximum");
        if (fail_cnt == 0 && filtered_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== clamped_edge_2d_convolution.f =====
+incdir+design
design/cec_pkg.sv
design/clamped_edge_2d_convolution.sv
dv/tb_clamped_edge_2d_convolution.sv
